@@ src/lkvc_pkg.sv @@
// shared types and constants for the lru key-value cache
package lkvc_pkg;

  // fixed field widths
  localparam int LOOKUP_KEY_W = 16;
  localparam int VALUE_W      = 32;
  localparam int CAP_W        = 5;

  // default sizing
  localparam int DEF_ENTRIES  = 16;
  localparam int DEF_KEY_BITS = 16;

  // configuration register map
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  // request opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } lkvc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted request, clear search results
    logic sweep_start;  // start a pass over all entries
    logic upd_phase;    // pass in progress rewrites recency ranks
    logic decide;       // apply the lookup outcome
    logic load_rsp;     // move the result into the output register
  } lkvc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_done;   // last entry of a pass handled this cycle
    logic need_update;  // recency ranks change for this request
    logic rsp_free;     // output register can take a result
  } lkvc_status_t;

endpackage

@@ src/lkvc_req_if.sv @@
// request channel: op, key and value with valid/ready
interface lkvc_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [lkvc_pkg::LOOKUP_KEY_W-1:0]   lookup_key;
  logic signed [lkvc_pkg::VALUE_W-1:0] store_value;

  modport source (output valid, output op, output lookup_key, output store_value,
                  input ready);
  modport sink (input valid, input op, input lookup_key, input store_value,
                output ready);
endinterface

@@ src/lkvc_rsp_if.sv @@
// response channel: found flag and value with valid/ready
interface lkvc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [lkvc_pkg::VALUE_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink (input valid, input found, input read_value, output ready);
endinterface

@@ src/lkvc_ctrl.sv @@
// request sequencer: accept, scan, decide, rank update when needed, respond
module lkvc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  lkvc_pkg::lkvc_status_t status,
  output lkvc_pkg::lkvc_cmd_t    cmd
);
  import lkvc_pkg::*;

  lkvc_state_t state;
  lkvc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    req_ready       = 1'b0;
    cmd             = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture     = 1'b1;
          cmd.sweep_start = 1'b1;
          state_next      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.sweep_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.need_update) begin
          cmd.sweep_start = 1'b1;
          state_next      = ST_UPDATE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_UPDATE: begin
        cmd.upd_phase = 1'b1;
        if (status.sweep_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/lkvc_datapath.sv @@
// entry storage, associative search by sweep, recency update and output register
module lkvc_datapath #(
  parameter int ENTRIES  = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkvc_pkg::DEF_KEY_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lkvc_pkg::lkvc_cmd_t                 cmd,
  output lkvc_pkg::lkvc_status_t              status,
  input  logic [lkvc_pkg::CAP_W-1:0]          capacity,
  input  logic                                op,
  input  logic [lkvc_pkg::LOOKUP_KEY_W-1:0]   lookup_key,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] store_value,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic                                found,
  output logic signed [lkvc_pkg::VALUE_W-1:0] read_value
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KW    = (KEY_BITS < LOOKUP_KEY_W) ? KEY_BITS : LOOKUP_KEY_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // storage
  logic [KW-1:0]      key_mem   [ENTRIES];
  logic [VALUE_W-1:0] value_mem [ENTRIES];
  logic [IDX_W-1:0]   rank_mem  [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]   occupancy;

  // latched request
  logic               req_op;
  logic [KW-1:0]      req_key;
  logic [VALUE_W-1:0] req_value;

  // sweep address and read stage
  logic               sweep_on;
  logic [IDX_W-1:0]   sweep_idx;
  logic               pipe_on;
  logic [IDX_W-1:0]   pipe_idx;
  logic [KW-1:0]      key_q;
  logic [IDX_W-1:0]   rank_q;
  logic [VALUE_W-1:0] value_q;

  // search results
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [IDX_W-1:0]   free_idx;
  logic               free_found;
  logic               vic_found;
  logic [IDX_W-1:0]   vic_idx;
  logic [IDX_W-1:0]   vic_rank;

  // decision results
  logic [IDX_W-1:0]   tgt_idx;
  logic [CNT_W-1:0]   old_rank;
  logic               res_found;

  // decision logic
  logic [CW-1:0]      cap_ext;
  logic [CW-1:0]      eff_cap;
  logic               has_room;
  logic               wr_en;
  logic               ins_en;
  logic [IDX_W-1:0]   dec_idx;
  logic [CNT_W-1:0]   dec_old;
  logic [IDX_W-1:0]   new_rank;
  logic               pipe_valid;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op    <= op;
      req_key   <= lookup_key[KW-1:0];
      req_value <= store_value;
    end
  end

  // sweep counter over all entries
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_on <= 1'b0;
      pipe_on  <= 1'b0;
    end else begin
      pipe_on <= sweep_on;
      if (cmd.sweep_start) begin
        sweep_on <= 1'b1;
      end else if (sweep_on && sweep_idx == LAST_IDX) begin
        sweep_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= sweep_idx;
    if (cmd.sweep_start) begin
      sweep_idx <= '0;
    end else if (sweep_on && sweep_idx != LAST_IDX) begin
      sweep_idx <= sweep_idx + IDX_W'(1);
    end
  end

  // registered reads of key and rank at the sweep address
  always_ff @(posedge clk) begin
    key_q  <= key_mem[sweep_idx];
    rank_q <= rank_mem[sweep_idx];
  end

  assign pipe_valid = entry_valid[pipe_idx];

  // scan: first match, first free slot, least recent entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      vic_found  <= 1'b0;
    end else if (pipe_on && !cmd.upd_phase) begin
      if (pipe_valid && key_q == req_key && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= pipe_idx;
        hit_rank  <= rank_q;
      end
      if (!pipe_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pipe_idx;
      end
      if (pipe_valid && (!vic_found || rank_q > vic_rank)) begin
        vic_found <= 1'b1;
        vic_idx   <= pipe_idx;
        vic_rank  <= rank_q;
      end
    end
  end

  // effective capacity: zero acts as one, saturate at the entry count
  assign cap_ext  = CW'(capacity);
  assign eff_cap  = (capacity == '0) ? CW'(1) :
                    ((cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext);
  assign has_room = CW'(occupancy) < eff_cap;

  // target slot and promotion threshold for this request
  always_comb begin
    wr_en   = 1'b0;
    ins_en  = 1'b0;
    dec_idx = hit_idx;
    dec_old = CNT_W'(hit_rank);
    if (req_op == OP_SET) begin
      wr_en = 1'b1;
      if (!hit_found) begin
        if (has_room) begin
          ins_en  = free_found;
          dec_idx = free_idx;
          dec_old = occupancy;
        end else begin
          dec_idx = vic_idx;
          dec_old = CNT_W'(vic_rank);
        end
      end
    end
  end

  // apply the decision: key/value write, slot allocation, hit value read
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      value_q <= value_mem[hit_idx];
      if (wr_en) begin
        value_mem[dec_idx] <= req_value;
        if (!hit_found) begin
          key_mem[dec_idx] <= req_key;
        end
      end
      tgt_idx   <= dec_idx;
      old_rank  <= dec_old;
      res_found <= (req_op == OP_GET) && hit_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else if (cmd.decide && ins_en) begin
      entry_valid[dec_idx] <= 1'b1;
      occupancy            <= occupancy + CNT_W'(1);
    end
  end

  // rank rewrite: target becomes most recent, more recent entries age by one
  always_comb begin
    new_rank = rank_q;
    if (pipe_idx == tgt_idx) begin
      new_rank = '0;
    end else if (pipe_valid && CNT_W'(rank_q) < old_rank) begin
      new_rank = rank_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_on && cmd.upd_phase) begin
      rank_mem[pipe_idx] <= new_rank;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      found      <= res_found;
      read_value <= res_found ? value_q : '0;
    end
  end

  // status to the controller
  assign status.sweep_done  = pipe_on && pipe_idx == LAST_IDX;
  assign status.need_update = (req_op == OP_SET) || hit_found;
  assign status.rsp_free    = !rsp_valid || rsp_ready;

endmodule

@@ src/lru_key_value_cache_unit.sv @@
// lru key-value cache: top level with configuration port and channel wiring
// get hit and set make two passes over the entries, a scan and a rank update;
//   get miss makes the scan pass only; each pass handles one entry a cycle
// one transaction at a time: a new request is taken only after the last result is loaded
//   into the output register, once that register is free
// reset: synchronous; clears valid bits, occupancy and control, capacity back to 16
module lru_key_value_cache_unit #(
  parameter int ENTRIES  = lkvc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkvc_pkg::DEF_KEY_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  lkvc_req_if.sink                        req,
  lkvc_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkvc_pkg::PADDR_W-1:0]    paddr,
  input  logic [lkvc_pkg::PDATA_W-1:0]    pwdata,
  output logic [lkvc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] capacity;
  lkvc_cmd_t        cmd;
  lkvc_status_t     status;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // register readback
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  // controller
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  lkvc_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .capacity    (capacity),
    .op          (req.op),
    .lookup_key  (req.lookup_key),
    .store_value (req.store_value),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .found       (rsp.found),
    .read_value  (rsp.read_value)
  );

  // one transaction in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_rsp |-> (!rsp.valid || rsp.ready))
    else $error("result loaded over a pending response");

  // a response appears only after the controller loads one
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.load_rsp))
    else $error("response valid without a load");

endmodule

@@ tb/tb_lru_key_value_cache_unit.sv @@
// testbench for the lru key-value cache: self-checking random and directed traffic
module tb_lru_key_value_cache_unit;
  import lkvc_pkg::*;

  localparam int SLOTS      = DEF_ENTRIES;
  localparam int POOL_SIZE  = 24;
  localparam int TAIL_WAIT  = 2 * SLOTS + 8;
  localparam int RUN_LIMIT  = 8_000_000;

  typedef struct packed {
    logic                      op;
    logic [LOOKUP_KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] value;
  } cache_rsp_t;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lkvc_req_if req_bus ();
  lkvc_rsp_if rsp_bus ();

  lru_key_value_cache_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the cache contents
  logic                      slot_used [SLOTS];
  logic [LOOKUP_KEY_W-1:0]   slot_key  [SLOTS];
  logic signed [VALUE_W-1:0] slot_value[SLOTS];
  logic [3:0]                slot_rank [SLOTS];
  logic [4:0]                used_count;
  logic [CAP_W-1:0]          capacity_reg;

  cache_req_t request_backlog[$];
  cache_rsp_t pending_replies[$];
  int         n_queued  = 0;
  int         n_replied = 0;
  int         fail_count = 0;
  flow_mode_t flow = FLOW_FREE;
  logic [LOOKUP_KEY_W-1:0] key_pool[POOL_SIZE];

  function automatic int usable_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > SLOTS) return SLOTS;
    return int'(capacity_reg);
  endfunction

  // move a slot to the front, younger slots age by one
  function automatic void make_most_recent(int s);
    logic [3:0] old_rank;
    old_rank = slot_rank[s];
    for (int j = 0; j < SLOTS; j++)
      if (slot_used[j] && j != s && slot_rank[j] < old_rank)
        slot_rank[j] = slot_rank[j] + 1'b1;
    slot_rank[s] = '0;
  endfunction

  // one get or set against the shadow cache, returns the expected reply
  function automatic cache_rsp_t lru_access(cache_req_t r);
    cache_rsp_t res;
    int hit;
    int slot;
    int victim;
    res = '0;
    hit = -1;
    slot = -1;
    victim = -1;
    for (int j = 0; j < SLOTS; j++)
      if (hit < 0 && slot_used[j] && slot_key[j] == r.key) hit = j;

    if (r.op == OP_GET) begin
      if (hit >= 0) begin
        res.found = 1'b1;
        res.value = slot_value[hit];
        make_most_recent(hit);
      end
      return res;
    end

    if (hit >= 0) begin
      slot_value[hit] = r.value;
      make_most_recent(hit);
    end else if (used_count < usable_capacity()) begin
      // insert into the lowest free slot
      for (int j = 0; j < SLOTS; j++)
        if (slot < 0 && !slot_used[j]) slot = j;
      for (int j = 0; j < SLOTS; j++)
        if (slot_used[j]) slot_rank[j] = slot_rank[j] + 1'b1;
      slot_used[slot]  = 1'b1;
      slot_key[slot]   = r.key;
      slot_value[slot] = r.value;
      slot_rank[slot]  = '0;
      used_count       = used_count + 1'b1;
    end else begin
      // replace the least recent entry
      for (int j = 0; j < SLOTS; j++)
        if (slot_used[j] && (victim < 0 || slot_rank[j] > slot_rank[victim])) victim = j;
      slot_key[victim]   = r.key;
      slot_value[victim] = r.value;
      make_most_recent(victim);
    end
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin : drive_requests
    cache_req_t nxt;
    logic       gap;
    if (rst) begin
      req_bus.valid       <= 1'b0;
      req_bus.op          <= OP_GET;
      req_bus.lookup_key  <= '0;
      req_bus.store_value <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        nxt = '{req_bus.op, req_bus.lookup_key, req_bus.store_value};
        pending_replies.push_back(lru_access(nxt));
      end
      if (!req_bus.valid || req_bus.ready) begin
        gap = (flow == FLOW_SRC_GAPS && $urandom_range(99) < 59) ||
              (flow == FLOW_BOTH && $urandom_range(99) < 23);
        if (request_backlog.size() != 0 && !gap) begin
          nxt = request_backlog.pop_front();
          req_bus.valid       <= 1'b1;
          req_bus.op          <= nxt.op;
          req_bus.lookup_key  <= nxt.key;
          req_bus.store_value <= nxt.value;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor and checker
  always @(posedge clk) begin : check_replies
    cache_rsp_t want;
    logic       stall;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_replied++;
        if (pending_replies.size() == 0) begin
          $error("reply transaction with no request outstanding: found %0d, read_value %0d",
                 rsp_bus.found, rsp_bus.read_value);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (rsp_bus.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, rsp_bus.found);
            fail_count++;
          end
          if (rsp_bus.read_value !== want.value) begin
            $error("read_value: expected %0d, actual %0d", want.value, rsp_bus.read_value);
            fail_count++;
          end
        end
      end
      stall = (flow == FLOW_SINK_STALLS && $urandom_range(99) < 59) ||
              (flow == FLOW_BOTH && $urandom_range(99) < 23);
      rsp_bus.ready <= !stall;
    end
  end

  task automatic queue_request(logic op, logic [LOOKUP_KEY_W-1:0] key,
                               logic signed [VALUE_W-1:0] value);
    request_backlog.push_back('{op, key, value});
    n_queued++;
  endtask

  // mostly keys from a small pool so that hits and evictions happen
  task automatic queue_random_requests(int count);
    int                        pool_lim;
    logic [LOOKUP_KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
    pool_lim = usable_capacity() + 3;
    if (pool_lim > POOL_SIZE) pool_lim = POOL_SIZE;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_lim - 1)];
      else key = LOOKUP_KEY_W'($urandom);
      case ($urandom_range(9))
        0:       value = 32'sh8000_0000;
        1:       value = 32'sh7FFF_FFFF;
        default: value = $urandom;
      endcase
      queue_request($urandom_range(1) ? OP_SET : OP_GET, key, value);
    end
  endtask

  task automatic wait_drained();
    while (n_replied < n_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the capacity register, only while idle
  task automatic write_capacity(logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(REG_CAPACITY));
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    capacity_reg = data[CAP_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // main sequence
  initial begin : stimulus
    logic [PDATA_W-1:0] cap_plan[10];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;

    for (int j = 0; j < SLOTS; j++) begin
      slot_used[j]  = 1'b0;
      slot_key[j]   = '0;
      slot_value[j] = '0;
      slot_rank[j]  = '0;
    end
    used_count   = '0;
    capacity_reg = CAPACITY_RESET;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = LOOKUP_KEY_W'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: miss on empty, extremes of key and value, update of a stored key
    flow = FLOW_FREE;
    queue_request(OP_GET, 16'h0000, 32'sd0);
    queue_request(OP_SET, 16'h0000, 32'sh7FFF_FFFF);
    queue_request(OP_GET, 16'h0000, 32'sd0);
    queue_request(OP_SET, 16'hFFFF, 32'sh8000_0000);
    queue_request(OP_GET, 16'hFFFF, 32'sh1234_5678);
    queue_request(OP_SET, 16'h0000, -32'sd1);
    queue_request(OP_GET, 16'h0000, 32'sd0);
    queue_request(OP_GET, 16'h1234, 32'sd0);
    wait_drained();

    // capacity zero acts as one and sits below the occupancy: sets replace the oldest
    write_capacity(32'h0000_0000);
    queue_request(OP_SET, 16'h0055, 32'sd5);
    queue_request(OP_GET, 16'hFFFF, 32'sd0);
    queue_request(OP_GET, 16'h0055, 32'sd0);
    queue_request(OP_GET, 16'h0000, 32'sd0);
    queue_request(OP_SET, 16'h00AA, 32'sh0000_AAAA);
    queue_request(OP_GET, 16'h0055, 32'sd0);
    queue_request(OP_GET, 16'h00AA, 32'sd0);
    wait_drained();

    // capacity above the slot count saturates at the slot count, new keys go to free slots
    write_capacity(32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++)
      queue_request(OP_SET, LOOKUP_KEY_W'(16'h0100 + i), VALUE_W'(i));
    wait_drained();

    // random phases over several capacities and flow-control patterns
    cap_plan = '{32'd16, 32'd1, 32'd5, 32'h0000_0011, 32'd8,
                 32'd0, 32'd3, 32'd12, 32'hFFFF_FFE2, 32'hFFFF_FFFF};
    for (int p = 0; p < 10; p++) begin
      write_capacity(cap_plan[p]);
      flow = flow_mode_t'(p % 4);
      queue_random_requests(70);
      wait_drained();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d expected replies never arrived", pending_replies.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ lru_key_value_cache_unit.f @@
src/lkvc_pkg.sv
src/lkvc_req_if.sv
src/lkvc_rsp_if.sv
src/lkvc_ctrl.sv
src/lkvc_datapath.sv
src/lru_key_value_cache_unit.sv
tb/tb_lru_key_value_cache_unit.sv
